// ----- rtl/core/sha1bs_pkg.sv -----
// Package for the SHA-1 byte stream hash: states and hash constants.
package sha1bs_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_PAD,
    ST_EMIT
  } state_t;

  localparam int unsigned NUM_WORDS  = 5;
  localparam int unsigned NUM_ROUNDS = 80;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

// ----- rtl/core/sha1_byte_stream_hash.sv -----
// SHA-1 hash engine taking a message one byte per transaction.
// Usage and timing: a data byte is taken on each handshake while idle. The
// 64th byte of each block starts the compression, one round per cycle on a
// single round unit, then the chaining add; in_ready is low meanwhile.
// Unless the message is too long, the end-of-message transaction inserts 9
// to 72 padding and length bytes at one byte per cycle, pausing while a
// full block is compressed (one or two more blocks), and finally presents the
// five digest words, one per out_ready cycle. A message whose bit count
// passes 2^64 - 1 returns five zero words with too_long set. After the fifth
// word the engine is back in its reset state, ready for the next message.
module sha1_byte_stream_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  msg_byte,
  input  logic        byte_present,
  input  logic        msg_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic        word_last,
  output logic        too_long
);
  import sha1bs_pkg::*;

  state_t state, state_next;

  logic [511:0] blk;
  logic [31:0]  chain [NUM_WORDS];
  logic [31:0]  a, b, c, d, e;
  logic [6:0]   rnd;
  logic [5:0]   fill;
  logic [63:0]  bit_length;
  logic         ovf;
  logic         finishing;
  logic         marked;
  logic         len_phase;
  logic [2:0]   widx;

  logic         in_acc;
  logic         push_idle;
  logic         push_en;
  logic [7:0]   push_val;
  logic         block_full;
  logic         len_sel;
  logic [63:0]  len_shift;
  logic         wrap;
  logic         ovf_next;
  logic         clear;

  logic [31:0]  w_cur;
  logic [31:0]  w_mix;
  logic [31:0]  w_new;
  logic [31:0]  f_val;
  logic [31:0]  k_val;
  logic [31:0]  t_val;

  assign in_acc    = in_valid && in_ready;
  assign push_idle = in_acc && byte_present && !ovf;
  assign wrap      = &bit_length[63:3];
  assign ovf_next  = ovf || (push_idle && wrap);

  assign len_sel   = marked && (len_phase || (fill == 6'd56));
  assign len_shift = bit_length >> {~fill[2:0], 3'b000};

  always_comb begin
    push_en  = 1'b0;
    push_val = msg_byte;
    if (state == ST_IDLE) begin
      push_en = push_idle;
    end else if (state == ST_PAD) begin
      push_en = 1'b1;
      if (!marked) begin
        push_val = PAD_MARK;
      end else if (len_sel) begin
        push_val = len_shift[7:0];
      end else begin
        push_val = 8'h00;
      end
    end
  end

  assign block_full = push_en && (fill == 6'd63);

  // round unit
  assign w_cur = blk[511:480];
  assign w_mix = blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ blk[511:480];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (rnd < 7'd20) begin
      f_val = (b & c) | (~b & d);
      k_val = K0;
    end else if (rnd < 7'd40) begin
      f_val = b ^ c ^ d;
      k_val = K1;
    end else if (rnd < 7'd60) begin
      f_val = (b & c) | (b & d) | (c & d);
      k_val = K2;
    end else begin
      f_val = b ^ c ^ d;
      k_val = K3;
    end
  end

  assign t_val = {a[26:0], a[31:27]} + f_val + e + w_cur + k_val;

  // control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_acc) begin
          if (block_full) begin
            state_next = ST_ROUND;
          end else if (msg_end) begin
            state_next = ovf_next ? ST_EMIT : ST_PAD;
          end
        end
      end
      ST_ROUND: begin
        if (rnd == 7'(NUM_ROUNDS - 1)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: begin
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (ovf || len_phase) begin
          state_next = ST_EMIT;
        end else begin
          state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (block_full) begin
          state_next = ST_ROUND;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready && (widx == 3'(NUM_WORDS - 1))) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign clear = (state == ST_EMIT) && out_ready && (widx == 3'(NUM_WORDS - 1));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      state      <= ST_IDLE;
      chain[0]   <= H0;
      chain[1]   <= H1;
      chain[2]   <= H2;
      chain[3]   <= H3;
      chain[4]   <= H4;
      rnd        <= '0;
      fill       <= '0;
      bit_length <= '0;
      ovf        <= 1'b0;
      finishing  <= 1'b0;
      marked     <= 1'b0;
      len_phase  <= 1'b0;
      widx       <= '0;
    end else begin
      state <= state_next;
      if (push_en) begin
        fill <= fill + 6'd1;
      end
      if (state == ST_IDLE && in_acc) begin
        finishing <= msg_end;
        ovf       <= ovf_next;
        if (push_idle) begin
          bit_length <= bit_length + 64'd8;
        end
      end
      if (state == ST_PAD) begin
        marked <= 1'b1;
        if (len_sel) begin
          len_phase <= 1'b1;
        end
      end
      if (block_full) begin
        rnd <= '0;
      end else if (state == ST_ROUND) begin
        rnd <= rnd + 7'd1;
      end
      if (state == ST_FINAL) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
      if (state == ST_EMIT && out_ready) begin
        widx <= widx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_en) begin
      blk <= {blk[503:0], push_val};
    end else if (state == ST_ROUND) begin
      blk <= {blk[479:0], w_new};
    end
    if (block_full) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (state == ST_ROUND) begin
      a <= t_val;
      b <= a;
      c <= {b[1:0], b[31:2]};
      d <= c;
      e <= d;
    end
  end

  assign digest_word = ovf ? 32'd0 : chain[widx];
  assign word_last   = (widx == 3'(NUM_WORDS - 1));
  assign too_long    = ovf;

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output sides active together");

  a_round_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (rnd < 7'(NUM_ROUNDS)))
    else $error("round counter out of range");

  a_emit_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !ovf) |-> (fill == 6'd0 && len_phase))
    else $error("digest presented before padding completed");

  a_clean_restart: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && word_last) |=>
      (state == ST_IDLE && fill == 6'd0 && bit_length == 64'd0 && !ovf))
    else $error("state not cleared after digest");

endmodule
